// ----- rtl/huffman_tree_walk_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH

// Same-cycle implication.
`define HTWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/htwd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Table geometry, node entry layout, walk states and child helpers.
// ----------------------------------------------------------------------------
package htwd_pkg;

  localparam int NODE_COUNT = 511;
  localparam int IDX_W      = 9;
  localparam int CHILD_W    = 10;
  localparam int SYM_W      = 8;
  localparam int CNT_W      = 4;
  localparam int BYTE_BITS  = 8;

  localparam logic [CHILD_W-1:0] CHILD_NONE = '1;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [CHILD_W-1:0] left;
    logic [CHILD_W-1:0] right;
  } node_entry_t;

  localparam node_entry_t ABSENT_ENTRY = '{symbol: '0, left: CHILD_NONE, right: CHILD_NONE};

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FILL,
    S_CHILD
  } walk_state_t;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  function automatic logic child_present(input logic [CHILD_W-1:0] raw);
    child_present = (raw < CHILD_W'(NODE_COUNT));
  endfunction

  function automatic logic entry_is_leaf(input node_entry_t e);
    entry_is_leaf = !child_present(e.left) && !child_present(e.right);
  endfunction

endpackage

// ----- rtl/huffman_tree_walk_decoder.sv -----
// Sequence: a byte is accepted in S_IDLE; whenever the current node is not held (after a leaf,
// an absent child, a load or a root write) it is fetched through S_RUN and S_FILL, or filled as
// absent in S_RUN if it lies past the table; a bit that takes a present child reads it in S_RUN
// and evaluates it in S_CHILD, a bit that hits an absent child resolves in S_RUN, and S_RUN closes
// the byte; a stalled output adds its wait. Transactions: one at a time, taken only in S_IDLE.
// Reset: synchronous; root and walk position return to 0, the node table is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder
// Loads a node table into a synchronous RAM and walks it bit by bit, MSB first,
// emitting a symbol at each leaf or an error at an absent child.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_defines.svh"

module huffman_tree_walk_decoder
  import htwd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration: root index
  input  logic               cfg_write_en,
  input  logic [IDX_W-1:0]   cfg_write_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [IDX_W-1:0]   node_index,
  input  logic [SYM_W-1:0]   node_symbol,
  input  logic signed [CHILD_W-1:0] left_child,
  input  logic signed [CHILD_W-1:0] right_child,
  input  logic [SYM_W-1:0]   code_byte,
  input  logic [CNT_W-1:0]   bit_count,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SYM_W-1:0]   out_symbol,
  output logic               last_of_run,
  output logic               walk_error
);

  // Node table: one write port for loads, one registered read port for the walk.
  node_entry_t node_mem [NODE_COUNT];
  node_entry_t rd_data;

  walk_state_t state, state_next;

  logic [IDX_W-1:0]  root_index;
  logic [IDX_W-1:0]  cur_node;
  node_entry_t       cur_entry;
  logic              cur_valid;
  logic [IDX_W-1:0]  child_idx;
  logic [BYTE_BITS-1:0] byte_sh;
  logic [CNT_W-1:0]  bits_left;

  // One result is held back until the next one shows up or the byte ends,
  // since only then is it known whether it is the last of the run.
  logic              pend_valid;
  logic [SYM_W-1:0]  pend_sym;
  logic              pend_err;

  logic              in_accept;
  logic [CNT_W-1:0]  cnt_clamped;
  logic              slot_free;
  logic [CHILD_W-1:0] cur_child;
  logic              cur_child_ok;
  logic              rd_is_leaf;
  logic              cur_in_range;

  // control
  logic              mem_we;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic              rd_for_child;
  logic              fill_absent;
  logic              fill_mem;
  logic              push;
  logic              push_last;
  logic              advance;
  logic              to_root;
  logic              descend;
  logic              new_err;
  logic              new_sym;

  assign in_accept    = in_valid && in_ready;
  assign cnt_clamped  = (bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : bit_count;
  assign slot_free    = !out_valid || out_ready;
  assign cur_child    = byte_sh[BYTE_BITS-1] ? cur_entry.right : cur_entry.left;
  assign cur_child_ok = child_present(cur_child);
  assign rd_is_leaf   = entry_is_leaf(rd_data);
  assign cur_in_range = (cur_node < IDX_W'(NODE_COUNT));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && (action == ACT_DECODE) && (cnt_clamped != '0)) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (bits_left == '0) begin
          if (!pend_valid || slot_free) begin
            state_next = S_IDLE;
          end
        end else if (!cur_valid) begin
          if (cur_in_range) begin
            state_next = S_FILL;
          end
        end else if (cur_child_ok) begin
          state_next = S_CHILD;
        end
      end
      S_FILL: begin
        state_next = S_RUN;
      end
      S_CHILD: begin
        if (!(rd_is_leaf && pend_valid && !slot_free)) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = cur_node;
    rd_for_child = 1'b0;
    fill_absent  = 1'b0;
    fill_mem     = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    advance      = 1'b0;
    to_root      = 1'b0;
    descend      = 1'b0;
    new_err      = 1'b0;
    new_sym      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // drop loads aimed past the end of the table
        mem_we   = in_valid && (action == ACT_LOAD) && (node_index < IDX_W'(NODE_COUNT));
      end
      S_RUN: begin
        if (bits_left == '0) begin
          // flush the held result, flagged as last
          if (pend_valid && slot_free) begin
            push      = 1'b1;
            push_last = 1'b1;
          end
        end else if (!cur_valid) begin
          // refetch the current node; an out-of-range node reads as having no children
          if (cur_in_range) begin
            mem_rd_en = 1'b1;
          end else begin
            fill_absent = 1'b1;
          end
        end else if (!cur_child_ok) begin
          if (!pend_valid || slot_free) begin
            push    = pend_valid;
            new_err = 1'b1;
            advance = 1'b1;
            to_root = 1'b1;
          end
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = cur_child[IDX_W-1:0];
          rd_for_child = 1'b1;
        end
      end
      S_FILL: begin
        fill_mem = 1'b1;
      end
      S_CHILD: begin
        if (rd_is_leaf) begin
          if (!pend_valid || slot_free) begin
            push    = pend_valid;
            new_sym = 1'b1;
            advance = 1'b1;
            to_root = 1'b1;
          end
        end else begin
          descend = 1'b1;
          advance = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Node table RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[node_index] <= '{symbol: node_symbol,
                                left:   left_child,
                                right:  right_child};
    end
    if (mem_rd_en) begin
      rd_data <= node_mem[mem_rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_index <= '0;
      cur_node   <= '0;
      cur_valid  <= 1'b0;
      bits_left  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (in_accept) begin
        if (action == ACT_LOAD) begin
          // a load may overwrite the cached current node
          cur_valid <= 1'b0;
        end else begin
          bits_left <= cnt_clamped;
        end
      end

      if (fill_absent || fill_mem || descend) begin
        cur_valid <= 1'b1;
      end
      if (descend) begin
        cur_node <= child_idx;
      end
      if (advance) begin
        bits_left <= bits_left - CNT_W'(1);
      end
      if (to_root) begin
        cur_node  <= root_index;
        cur_valid <= 1'b0;
      end

      if (new_err || new_sym) begin
        pend_valid <= 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_write_en) begin
        root_index <= cfg_write_data;
        cur_node   <= cfg_write_data;
        cur_valid  <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept && (action == ACT_DECODE)) begin
      byte_sh <= code_byte;
    end else if (advance) begin
      byte_sh <= {byte_sh[BYTE_BITS-2:0], 1'b0};
    end

    if (fill_absent) begin
      cur_entry <= ABSENT_ENTRY;
    end else if (fill_mem || descend) begin
      cur_entry <= rd_data;
    end

    if (rd_for_child) begin
      child_idx <= cur_child[IDX_W-1:0];
    end

    if (new_err) begin
      pend_sym <= '0;
      pend_err <= 1'b1;
    end else if (new_sym) begin
      pend_sym <= rd_data.symbol;
      pend_err <= 1'b0;
    end

    if (push) begin
      out_symbol  <= pend_sym;
      walk_error  <= pend_err;
      last_of_run <= push_last;
    end
  end

  // Assertions
  `HTWD_ASSERT_NOW(a_push_into_free_slot, push, slot_free,
                   "result pushed over an unaccepted output")
  `HTWD_ASSERT_NOW(a_idle_no_pending, state == S_IDLE, !pend_valid,
                   "held result left behind after a byte finished")
  `HTWD_ASSERT_NEXT(a_child_after_read, rd_for_child, state == S_CHILD,
                    "child read not followed by child evaluation")

endmodule
